// File: rtl/core/mabh_pkg.sv
// Shared types and constants of the memory access bin histogram.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mabh_pkg;

   // Field widths
   localparam int ADDR_W   = 40;
   localparam int MB_SHIFT = 20;
   localparam int NUM_W    = ADDR_W - MB_SHIFT;
   localparam int BSZ_W    = 12;
   localparam int PERIOD_W = 32;
   localparam int CNT_W    = 32;
   localparam int TOT_W    = 64;
   localparam int DBIN_W   = 4;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD   = 2'd2;

   localparam logic [BSZ_W-1:0]    BIN_SIZE_RST = 12'd16;
   localparam logic [PERIOD_W-1:0] PERIOD_RST   = 32'd100;

   // Default geometry
   localparam int NUM_CORES_DEF = 2;
   localparam int NUM_BINS_DEF  = 16;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic             dump;    // dump and clear all bins first
      logic             bin_op;  // then bump one bin
      logic             kern;
      logic             core;
      logic [NUM_W-1:0] num;     // address in MiB units
      logic [TOT_W-1:0] total;   // total including this access
      logic [TOT_W-1:0] io_cnt;  // I/O total before this access
   } mabh_entry_type;

   typedef struct packed {
      logic full;
      logic clearing;
   } mabh_stall_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_DIV,
      ST_WR
   } mabh_state_type;

endpackage

`default_nettype wire

// File: rtl/core/memory_access_bin_histogram_core.sv
// Memory access bin histogram, top level over mabh_front, mabh_queue, mabh_back; uses mabh_pkg.
// Flow: an access that neither dumps nor bins is not queued; a binned access holds the back
// end through pop, bit-serial divide and bin write.
// Dump: a dump pops, scans all 2^(1+log2(NUM_CORES)+log2(NUM_BINS)) bins (64), then marks the last record.
// Reset: synchronous; a clearing pass zeroes the bins, no beat accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module memory_access_bin_histogram_core #(
   parameter int NUM_CORES = mabh_pkg::NUM_CORES_DEF,
   parameter int NUM_BINS  = mabh_pkg::NUM_BINS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration writes, only while the block is idle
   input  wire logic                            csr_write_enable,
   input  wire logic [mabh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mabh_pkg::CSR_DATA_W-1:0] csr_write_data,
   // access beats
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_core_id,
   input  wire logic [mabh_pkg::ADDR_W-1:0]     req_physical_address,
   input  wire logic                            req_io_access,
   input  wire logic                            req_kernel_mode,
   // dump record beats
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_dump_core,
   output logic                                 rsp_dump_kernel,
   output logic [mabh_pkg::DBIN_W-1:0]          rsp_dump_bin,
   output logic [mabh_pkg::CNT_W-1:0]           rsp_dump_count,
   output logic [mabh_pkg::TOT_W-1:0]           rsp_total_accesses,
   output logic [mabh_pkg::TOT_W-1:0]           rsp_io_accesses,
   output logic                                 rsp_last_record
);
   import mabh_pkg::*;

   // The front end keeps the config registers and all running totals, so
   // every snapshot a dump needs travels with the queued access. Only
   // accesses that dump or bin are queued.
   mabh_stall_type   stall;
   logic             q_full, back_clearing;
   logic             q_push, q_pop, q_not_empty;
   mabh_entry_type   q_in, q_out;
   logic [BSZ_W-1:0] bin_size;

   assign stall = '{full: q_full, clearing: back_clearing};

   mabh_front #(
      .NUM_CORES (NUM_CORES),
      .NUM_BINS  (NUM_BINS)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_core_id          (req_core_id),
      .req_physical_address (req_physical_address),
      .req_io_access        (req_io_access),
      .req_kernel_mode      (req_kernel_mode),
      .stall                (stall),
      .push                 (q_push),
      .push_entry           (q_in),
      .bin_size             (bin_size)
   );

   // Decouples the totals bookkeeping from the slow bin updates and dumps.
   mabh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .pop_entry  (q_out),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   // Back end: clearing pass, dump scan (one bin per cycle unless the
   // result register is stalled), divide, then bin read-modify-write.
   mabh_back #(
      .NUM_CORES (NUM_CORES),
      .NUM_BINS  (NUM_BINS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_not_empty),
      .q_entry            (q_out),
      .q_pop              (q_pop),
      .bin_size           (bin_size),
      .clearing           (back_clearing),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_dump_core      (rsp_dump_core),
      .rsp_dump_kernel    (rsp_dump_kernel),
      .rsp_dump_bin       (rsp_dump_bin),
      .rsp_dump_count     (rsp_dump_count),
      .rsp_total_accesses (rsp_total_accesses),
      .rsp_io_accesses    (rsp_io_accesses),
      .rsp_last_record    (rsp_last_record)
   );

   // no access taken while the bin memory is being cleared
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      stall.clearing |-> !req_ready)
      else $error("access beat offered ready during clearing pass");

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      stall.full |-> !q_push)
      else $error("push into full queue");

   // a zero count only appears as the single record of an empty dump
   a_zero_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_dump_count == '0)) |-> rsp_last_record)
      else $error("zero-count record not marked last");

   // the back end does not drain the queue during the clearing pass
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      stall.clearing |-> !q_pop)
      else $error("queue popped during clearing pass");

endmodule

`default_nettype wire

// File: rtl/core/mabh_front.sv
// Front end: config registers, input handshake, running totals, classification.
// Depends on mabh_pkg; feeds mabh_queue.
`timescale 1ns / 1ps
`default_nettype none

module mabh_front #(
   parameter int NUM_CORES = mabh_pkg::NUM_CORES_DEF,
   parameter int NUM_BINS  = mabh_pkg::NUM_BINS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [mabh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mabh_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_core_id,
   input  wire logic [mabh_pkg::ADDR_W-1:0]     req_physical_address,
   input  wire logic                            req_io_access,
   input  wire logic                            req_kernel_mode,
   input  mabh_pkg::mabh_stall_type             stall,
   output logic                                 push,
   output mabh_pkg::mabh_entry_type             push_entry,
   output logic [mabh_pkg::BSZ_W-1:0]           bin_size
);
   import mabh_pkg::*;

   localparam int LIM_W = BSZ_W + $clog2(NUM_BINS + 1);
   localparam int CMP_W = (LIM_W > NUM_W) ? LIM_W : NUM_W;

   logic                enable_ff, enable_in;
   logic [BSZ_W-1:0]    bsz_ff, bsz_in;
   logic [LIM_W-1:0]    lim_ff, lim_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] pcount_ff, pcount_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic [TOT_W-1:0]    io_ff, io_in;

   logic                accept, count, dump_hit, core_ok, bin_ok;
   logic [PERIOD_W-1:0] pcount_inc;
   logic [TOT_W-1:0]    total_inc;
   logic [NUM_W-1:0]    num;

   assign req_ready  = !stall.full && !stall.clearing;
   assign accept     = req_valid && req_ready;
   assign count      = accept && enable_ff;
   assign pcount_inc = pcount_ff + 32'd1;
   assign dump_hit   = pcount_inc >= period_ff;
   assign total_inc  = total_ff + 64'd1;
   assign num        = req_physical_address[ADDR_W-1:MB_SHIFT];
   assign core_ok    = (NUM_CORES > 1) || !req_core_id;
   // bin size zero gives a zero limit, so nothing gets binned
   assign bin_ok     = !req_io_access && core_ok && (CMP_W'(num) < CMP_W'(lim_ff));
   assign bin_size   = bsz_ff;

   assign push              = count && (dump_hit || bin_ok);
   assign push_entry.dump   = dump_hit;
   assign push_entry.bin_op = bin_ok;
   assign push_entry.kern   = req_kernel_mode;
   assign push_entry.core   = req_core_id;
   assign push_entry.num    = num;
   assign push_entry.total  = total_inc;
   assign push_entry.io_cnt = io_ff;

   always_comb begin
      enable_in = enable_ff;
      bsz_in    = bsz_ff;
      lim_in    = lim_ff;
      period_in = period_ff;
      pcount_in = pcount_ff;
      total_in  = total_ff;
      io_in     = io_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE: begin
               enable_in = csr_write_data[0];
            end
            CSR_BIN_SIZE: begin
               bsz_in = csr_write_data[BSZ_W-1:0];
               lim_in = LIM_W'(csr_write_data[BSZ_W-1:0]) * LIM_W'(NUM_BINS);
            end
            CSR_PERIOD: begin
               period_in = csr_write_data[PERIOD_W-1:0];
            end
            default: begin
            end
         endcase
      end
      if (count) begin
         total_in  = total_inc;
         pcount_in = dump_hit ? '0 : pcount_inc;
         if (req_io_access) begin
            io_in = io_ff + 64'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         bsz_ff    <= BIN_SIZE_RST;
         lim_ff    <= LIM_W'(BIN_SIZE_RST) * LIM_W'(NUM_BINS);
         period_ff <= PERIOD_RST;
         pcount_ff <= '0;
         total_ff  <= '0;
         io_ff     <= '0;
      end else begin
         enable_ff <= enable_in;
         bsz_ff    <= bsz_in;
         lim_ff    <= lim_in;
         period_ff <= period_in;
         pcount_ff <= pcount_in;
         total_ff  <= total_in;
         io_ff     <= io_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/mabh_queue.sv
// Short FIFO of classified accesses between front and back end.
// Depends on mabh_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module mabh_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  mabh_pkg::mabh_entry_type push_entry,
   input  wire logic                pop,
   output mabh_pkg::mabh_entry_type pop_entry,
   output logic                     not_empty,
   output logic                     full
);
   import mabh_pkg::*;

   mabh_entry_type    entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/mabh_back.sv
// Back end: bin memory, clearing pass, dump scan, bit-serial bin divider,
// bin read-modify-write and the result register. Depends on mabh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mabh_back #(
   parameter int NUM_CORES = mabh_pkg::NUM_CORES_DEF,
   parameter int NUM_BINS  = mabh_pkg::NUM_BINS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid,
   input  mabh_pkg::mabh_entry_type         q_entry,
   output logic                             q_pop,
   input  wire logic [mabh_pkg::BSZ_W-1:0]  bin_size,
   output logic                             clearing,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_dump_core,
   output logic                             rsp_dump_kernel,
   output logic [mabh_pkg::DBIN_W-1:0]      rsp_dump_bin,
   output logic [mabh_pkg::CNT_W-1:0]       rsp_dump_count,
   output logic [mabh_pkg::TOT_W-1:0]       rsp_total_accesses,
   output logic [mabh_pkg::TOT_W-1:0]       rsp_io_accesses,
   output logic                             rsp_last_record
);
   import mabh_pkg::*;

   localparam int CORE_W    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int MEM_AW    = 1 + CORE_W + BIN_W;
   localparam int MEM_DEPTH = 1 << MEM_AW;
   localparam int SH_W      = (BIN_W > 1) ? $clog2(BIN_W) : 1;
   localparam int RW        = ((BSZ_W + BIN_W) > NUM_W) ? (BSZ_W + BIN_W) : NUM_W;
   localparam int BP_W      = (BIN_W > DBIN_W) ? BIN_W : DBIN_W;
   localparam logic [MEM_AW-1:0] SCAN_LAST = MEM_AW'(MEM_DEPTH - 1);

   // address layout {user map, core, bin}: kernel map scans first
   logic [CNT_W-1:0]  bin_mem [MEM_DEPTH];
   logic [CNT_W-1:0]  rd_data_ff;
   logic [MEM_AW-1:0] rd_addr;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   logic [CNT_W-1:0]  mem_wdata;

   mabh_state_type    state_ff, state_in;
   mabh_entry_type    ent_ff, ent_in;
   logic [MEM_AW-1:0] scan_ff, scan_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [BIN_W-1:0]  quo_ff, quo_in;
   logic [SH_W-1:0]   step_ff, step_in;
   logic              hold_vld_ff, hold_vld_in;
   logic [MEM_AW-1:0] hold_addr_ff, hold_addr_in;
   logic [CNT_W-1:0]  hold_cnt_ff, hold_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              rsp_core_ff, rsp_kern_ff, rsp_last_ff;
   logic [DBIN_W-1:0] rsp_bin_ff;
   logic [CNT_W-1:0]  rsp_cnt_ff;
   logic [TOT_W-1:0]  rsp_total_ff, rsp_io_ff;

   logic              out_free, out_load, out_empty, out_last;
   logic [MEM_AW-1:0] out_addr;
   logic [CNT_W-1:0]  out_cnt;
   logic [CORE_W-1:0] out_core_idx;
   logic [BP_W-1:0]   out_bin_pad;

   logic [RW-1:0]     dsh;
   logic              ge;
   logic [NUM_W-1:0]  rem_next;
   logic [BIN_W-1:0]  quo_next;
   logic              nz;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign out_core_idx = out_addr[BIN_W +: CORE_W];
   assign out_bin_pad  = BP_W'(out_addr[BIN_W-1:0]);
   assign nz           = rd_data_ff != '0;

   // one quotient bit per cycle, MSB first
   assign dsh      = RW'(bin_size) << step_ff;
   assign ge       = RW'(rem_ff) >= dsh;
   assign rem_next = ge ? (rem_ff - dsh[NUM_W-1:0]) : rem_ff;
   assign quo_next = BIN_W'({quo_ff, ge});

   assign clearing = state_ff == ST_CLEAR;

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      scan_in      = scan_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      hold_vld_in  = hold_vld_ff;
      hold_addr_in = hold_addr_ff;
      hold_cnt_in  = hold_cnt_ff;
      q_pop        = 1'b0;
      rd_addr      = scan_ff;
      mem_we       = 1'b0;
      mem_waddr    = scan_ff;
      mem_wdata    = '0;
      out_load     = 1'b0;
      out_empty    = 1'b0;
      out_last     = 1'b0;
      out_addr     = hold_addr_ff;
      out_cnt      = hold_cnt_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we  = 1'b1;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == SCAN_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               ent_in = q_entry;
               if (q_entry.dump) begin
                  scan_in  = '0;
                  rd_addr  = '0;
                  state_in = ST_SCAN;
               end else if (q_entry.bin_op) begin
                  rem_in   = q_entry.num;
                  quo_in   = '0;
                  step_in  = SH_W'(BIN_W - 1);
                  state_in = ST_DIV;
               end
            end
         end
         ST_SCAN: begin
            // rd_data_ff holds the entry at scan_ff; the newest nonzero bin
            // is held back so the final one can carry the last mark
            if (!nz || !hold_vld_ff || out_free) begin
               mem_we  = 1'b1;
               rd_addr = scan_ff + 1'b1;
               scan_in = scan_ff + 1'b1;
               if (nz) begin
                  out_load     = hold_vld_ff;
                  hold_vld_in  = 1'b1;
                  hold_addr_in = scan_ff;
                  hold_cnt_in  = rd_data_ff;
               end
               if (scan_ff == SCAN_LAST) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_last    = 1'b1;
               out_empty   = !hold_vld_ff;
               hold_vld_in = 1'b0;
               if (ent_ff.bin_op) begin
                  rem_in   = ent_ff.num;
                  quo_in   = '0;
                  step_in  = SH_W'(BIN_W - 1);
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            rem_in = rem_next;
            quo_in = quo_next;
            if (step_ff == '0) begin
               rd_addr  = {!ent_ff.kern, CORE_W'(ent_ff.core), quo_next};
               state_in = ST_WR;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_WR: begin
            mem_we    = 1'b1;
            mem_waddr = {!ent_ff.kern, CORE_W'(ent_ff.core), quo_ff};
            mem_wdata = rd_data_ff + 32'd1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff       <= ent_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      hold_addr_ff <= hold_addr_in;
      hold_cnt_ff  <= hold_cnt_in;
      if (out_load) begin
         rsp_core_ff  <= out_empty ? 1'b0 : out_core_idx[0];
         rsp_kern_ff  <= out_empty ? 1'b0 : !out_addr[MEM_AW-1];
         rsp_bin_ff   <= out_empty ? '0 : out_bin_pad[DBIN_W-1:0];
         rsp_cnt_ff   <= out_empty ? '0 : out_cnt;
         rsp_total_ff <= ent_ff.total;
         rsp_io_ff    <= ent_ff.io_cnt;
         rsp_last_ff  <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= bin_mem[rd_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dump_core      = rsp_core_ff;
   assign rsp_dump_kernel    = rsp_kern_ff;
   assign rsp_dump_bin       = rsp_bin_ff;
   assign rsp_dump_count     = rsp_cnt_ff;
   assign rsp_total_accesses = rsp_total_ff;
   assign rsp_io_accesses    = rsp_io_ff;
   assign rsp_last_record    = rsp_last_ff;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for memory_access_bin_histogram_core: directed access table,
// then randomized phases, each dump record compared against a typed table row or an in-bench histogram model.
// Depends on mabh_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_top;
   import mabh_pkg::*;

   localparam int NCORES     = NUM_CORES_DEF;
   localparam int NBINS      = NUM_BINS_DEF;
   localparam int CELLS      = NCORES * NBINS;
   localparam int SETTLE     = 200;        // covers queue drain plus a full bin scan
   localparam int HOLD_CYCLES = 400;       // long receiver stall, fills the queue
   localparam int CYCLE_LIMIT = 1_500_000;

   // One dump record as seen on the rsp_ side
   typedef struct packed {
      logic              core;
      logic              kern;
      logic [DBIN_W-1:0] bin;
      logic [CNT_W-1:0]  count;
      logic [TOT_W-1:0]  total;
      logic [TOT_W-1:0]  io;
      logic              last;
   } dump_rec_t;

   typedef enum logic { ROW_ACCESS, ROW_CSR } row_kind_t;

   // Directed stimulus row: either a register write or one access beat
   typedef struct {
      row_kind_t              kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  data;
      logic                   core;
      logic [ADDR_W-1:0]      addr;
      logic                   io;
      logic                   kern;
      bit                     typed;   // expected record written into the row
      dump_rec_t              want;
   } stim_row_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_core_id;
   logic [ADDR_W-1:0]     req_physical_address;
   logic                  req_io_access;
   logic                  req_kernel_mode;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_dump_core;
   logic                  rsp_dump_kernel;
   logic [DBIN_W-1:0]     rsp_dump_bin;
   logic [CNT_W-1:0]      rsp_dump_count;
   logic [TOT_W-1:0]      rsp_total_accesses;
   logic [TOT_W-1:0]      rsp_io_accesses;
   logic                  rsp_last_record;

   memory_access_bin_histogram_core dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_core_id          (req_core_id),
      .req_physical_address (req_physical_address),
      .req_io_access        (req_io_access),
      .req_kernel_mode      (req_kernel_mode),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_dump_core        (rsp_dump_core),
      .rsp_dump_kernel      (rsp_dump_kernel),
      .rsp_dump_bin         (rsp_dump_bin),
      .rsp_dump_count       (rsp_dump_count),
      .rsp_total_accesses   (rsp_total_accesses),
      .rsp_io_accesses      (rsp_io_accesses),
      .rsp_last_record      (rsp_last_record)
   );

   // ------------------------------------------------------------------
   // Histogram model state: bins, running totals, period counter, registers
   // ------------------------------------------------------------------
   logic [CNT_W-1:0]    kern_map [CELLS];
   logic [CNT_W-1:0]    user_map [CELLS];
   logic [TOT_W-1:0]    access_seen;
   logic [TOT_W-1:0]    io_seen;
   logic [PERIOD_W-1:0] since_dump;
   logic                cfg_enable;
   logic [BSZ_W-1:0]    cfg_bin_mb;
   logic [PERIOD_W-1:0] cfg_period;

   dump_rec_t step_records[$];   // records caused by the beat just accepted
   dump_rec_t pending_dumps[$];  // records still owed by the block, oldest first

   int unsigned errors      = 0;
   int unsigned cycle_count = 0;
   bit          gaps_on     = 1;  // random idle cycles on both sides
   bit          hold_results = 0; // one long stall of the receiver

   stim_row_t directed_rows[$];

   // ------------------------------------------------------------------
   // Clock and cycle limit
   // ------------------------------------------------------------------
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d dump records still owed", $time, pending_dumps.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------
   function automatic dump_rec_t mk_rec(logic core, logic kern, logic [DBIN_W-1:0] bin,
                                        logic [CNT_W-1:0] count, logic [TOT_W-1:0] total,
                                        logic [TOT_W-1:0] io, logic last);
      dump_rec_t r;
      r.core  = core;
      r.kern  = kern;
      r.bin   = bin;
      r.count = count;
      r.total = total;
      r.io    = io;
      r.last  = last;
      return r;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_ENABLE:   cfg_enable = data[0];
         CSR_BIN_SIZE: cfg_bin_mb = data[BSZ_W-1:0];
         CSR_PERIOD:   cfg_period = data[PERIOD_W-1:0];
         default: ;
      endcase
   endfunction

   // Counts one access; fills step_records with the dump it triggers, if any.
   function automatic void histogram_step(logic core, logic [ADDR_W-1:0] addr,
                                          logic io, logic kern);
      logic [ADDR_W-1:0] span;
      logic [ADDR_W-1:0] bin_no;
      logic [CNT_W-1:0]  v;
      dump_rec_t         tail;
      step_records.delete();
      if (!cfg_enable)
         return;
      access_seen++;
      since_dump++;
      // period of zero acts as one: the compare always hits
      if (since_dump >= cfg_period) begin
         since_dump = '0;
         for (int m = 1; m >= 0; m--) begin   // kernel map first
            for (int c = 0; c < NCORES; c++) begin
               for (int b = 0; b < NBINS; b++) begin
                  v = m ? kern_map[c*NBINS+b] : user_map[c*NBINS+b];
                  if (v != 0)
                     step_records.push_back(mk_rec(c[0], m[0], b[DBIN_W-1:0], v,
                                                   access_seen, io_seen, 1'b0));
                  if (m) kern_map[c*NBINS+b] = '0;
                  else   user_map[c*NBINS+b] = '0;
               end
            end
         end
         if (step_records.size() == 0)
            step_records.push_back(mk_rec(1'b0, 1'b0, '0, '0, access_seen, io_seen, 1'b0));
         tail = step_records.pop_back();
         tail.last = 1'b1;
         step_records.push_back(tail);
      end
      if (io) begin
         io_seen++;
      end else if (cfg_bin_mb != 0) begin
         span   = ADDR_W'(cfg_bin_mb) << MB_SHIFT;
         bin_no = addr / span;
         if (bin_no < NBINS) begin   // beyond the store: dropped
            if (kern) kern_map[int'(core)*NBINS + int'(bin_no)]++;
            else      user_map[int'(core)*NBINS + int'(bin_no)]++;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Result checking, sampled at the rising edge
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      dump_rec_t want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_dumps.size() == 0) begin
            $display("%0t: unexpected dump record, expected none actual core %0h kern %0h bin %0h count %0h",
                     $time, rsp_dump_core, rsp_dump_kernel, rsp_dump_bin, rsp_dump_count);
            errors++;
         end else begin
            want = pending_dumps.pop_front();
            check_field("dump_core",      want.core,  rsp_dump_core);
            check_field("dump_kernel",    want.kern,  rsp_dump_kernel);
            check_field("dump_bin",       want.bin,   rsp_dump_bin);
            check_field("dump_count",     want.count, rsp_dump_count);
            check_field("total_accesses", want.total, rsp_total_accesses);
            check_field("io_accesses",    want.io,    rsp_io_accesses);
            check_field("last_record",    want.last,  rsp_last_record);
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random idle before each beat, plus one long hold on request
   // ------------------------------------------------------------------
   initial begin
      int n;
      rsp_ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         n = gaps_on ? $urandom_range(0, 12) : 0;
         if (hold_results) begin
            n = HOLD_CYCLES;
            hold_results = 0;
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Sender and register helpers
   // ------------------------------------------------------------------
   task automatic send_access(logic core, logic [ADDR_W-1:0] addr, logic io, logic kern,
                              bit typed = 0, dump_rec_t want = '0);
      int gap;
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_core_id          <= core;
      req_physical_address <= addr;
      req_io_access        <= io;
      req_kernel_mode      <= kern;
      do @(posedge clock); while (req_ready !== 1'b1);
      histogram_step(core, addr, io, kern);
      if (typed) begin
         pending_dumps.push_back(want);
      end else begin
         foreach (step_records[i]) pending_dumps.push_back(step_records[i]);
      end
   endtask

   // Stop sending, let every owed record come out, then let the back end settle
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_dumps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      apply_csr(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_config(logic en, logic [BSZ_W-1:0] bin_mb, logic [PERIOD_W-1:0] period);
      drain_block();
      csr_write(CSR_ENABLE,   CSR_DATA_W'(en));
      csr_write(CSR_BIN_SIZE, CSR_DATA_W'(bin_mb));
      csr_write(CSR_PERIOD,   CSR_DATA_W'(period));
   endtask

   // Mostly addresses that land in a bin; some near bin edges, some anywhere
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [63:0] raw;
      logic [63:0] span;
      int unsigned sel;
      raw  = {$urandom, $urandom};
      span = 64'(cfg_bin_mb) << MB_SHIFT;
      sel  = $urandom_range(0, 9);
      if (span == 0 || sel < 2)
         return raw[ADDR_W-1:0];
      if (sel == 2)
         return ADDR_W'(span * $urandom_range(0, NBINS) - $urandom_range(0, 1));
      return ADDR_W'(raw % (span * NBINS));
   endfunction

   task automatic run_random(int count);
      for (int i = 0; i < count; i++)
         send_access($urandom_range(0, 1), pick_address(), $urandom_range(0, 4) == 0,
                     $urandom_range(0, 1));
   endtask

   function automatic stim_row_t acc(logic core, logic [ADDR_W-1:0] addr, logic io,
                                     logic kern);
      stim_row_t r;
      r.kind  = ROW_ACCESS;
      r.idx   = CSR_ENABLE;
      r.data  = '0;
      r.core  = core;
      r.addr  = addr;
      r.io    = io;
      r.kern  = kern;
      r.typed = 0;
      r.want  = '0;
      return r;
   endfunction

   function automatic stim_row_t acc_exp(logic core, logic [ADDR_W-1:0] addr, logic io,
                                         logic kern, dump_rec_t want);
      stim_row_t r;
      r       = acc(core, addr, io, kern);
      r.typed = 1;
      r.want  = want;
      return r;
   endfunction

   function automatic stim_row_t cfg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      stim_row_t r;
      r      = acc(1'b0, '0, 1'b0, 1'b0);
      r.kind = ROW_CSR;
      r.idx  = idx;
      r.data = data;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_ENABLE;
      csr_write_data       = '0;
      req_valid            = 1'b0;
      req_core_id          = 1'b0;
      req_physical_address = '0;
      req_io_access        = 1'b0;
      req_kernel_mode      = 1'b0;

      // model after reset
      foreach (kern_map[i]) kern_map[i] = '0;
      foreach (user_map[i]) user_map[i] = '0;
      access_seen = '0;
      io_seen     = '0;
      since_dump  = '0;
      cfg_enable  = 1'b0;
      cfg_bin_mb  = BIN_SIZE_RST;
      cfg_period  = PERIOD_RST;

      // Directed table. Typed rows are single-record dumps read straight off
      // the running totals; the rest go through the model.
      // disabled after reset: beat is ignored
      directed_rows.push_back(acc(1'b1, 40'hFF_FFFF_FFFF, 1'b0, 1'b1));
      directed_rows.push_back(cfg(CSR_PERIOD, 32'd1));
      directed_rows.push_back(cfg(CSR_ENABLE, 32'd1));
      // period one: empty dump first
      directed_rows.push_back(acc_exp(1'b0, 40'h0, 1'b0, 1'b0,
                                      mk_rec(0, 0, 4'd0, 32'd0, 64'd1, 64'd0, 1)));
      // I/O beat at top address; dumps user core 0 bin 0
      directed_rows.push_back(acc_exp(1'b1, 40'hFF_FFFF_FFFF, 1'b1, 1'b1,
                                      mk_rec(0, 0, 4'd0, 32'd1, 64'd2, 64'd0, 1)));
      // last bin, kernel, core 1
      directed_rows.push_back(acc_exp(1'b1, 40'h00_0F00_0000, 1'b0, 1'b1,
                                      mk_rec(0, 0, 4'd0, 32'd0, 64'd3, 64'd1, 1)));
      // first bin past the store: dropped
      directed_rows.push_back(acc_exp(1'b0, 40'h00_1000_0000, 1'b0, 1'b0,
                                      mk_rec(1, 1, 4'd15, 32'd1, 64'd4, 64'd1, 1)));
      // period zero behaves as one
      directed_rows.push_back(cfg(CSR_PERIOD, 32'd0));
      directed_rows.push_back(acc_exp(1'b0, 40'h00_0FFF_FFFF, 1'b0, 1'b1,
                                      mk_rec(0, 0, 4'd0, 32'd0, 64'd5, 64'd1, 1)));
      // bin size zero: counted, never binned
      directed_rows.push_back(cfg(CSR_BIN_SIZE, 32'd0));
      directed_rows.push_back(acc_exp(1'b1, 40'h00_0000_0123, 1'b0, 1'b0,
                                      mk_rec(0, 1, 4'd15, 32'd1, 64'd6, 64'd1, 1)));
      // widest bins, longest period
      directed_rows.push_back(cfg(CSR_BIN_SIZE, 32'd4095));
      directed_rows.push_back(cfg(CSR_PERIOD, 32'hFFFF_FFFF));
      directed_rows.push_back(acc(1'b1, 40'hFF_FFFF_FFFF, 1'b0, 1'b0));
      directed_rows.push_back(acc(1'b1, 40'h2_FFD0_0000, 1'b0, 1'b1));
      directed_rows.push_back(acc(1'b0, 40'hF_FEFF_FFFF, 1'b0, 1'b0));
      // period lowered below the running count: next beat dumps at once
      directed_rows.push_back(cfg(CSR_PERIOD, 32'd2));
      directed_rows.push_back(acc(1'b0, 40'h0, 1'b1, 1'b1));
      // narrowest bins
      directed_rows.push_back(cfg(CSR_BIN_SIZE, 32'd1));
      directed_rows.push_back(cfg(CSR_PERIOD, 32'd3));
      directed_rows.push_back(acc(1'b0, 40'h00_00F0_0000, 1'b0, 1'b0));
      directed_rows.push_back(acc(1'b1, 40'h00_0010_0000, 1'b0, 1'b0));
      directed_rows.push_back(acc(1'b0, 40'h00_0100_0000, 1'b0, 1'b1));
      directed_rows.push_back(acc(1'b1, 40'h00_000F_FFFF, 1'b0, 1'b1));

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      // clearing pass after reset, before any register write
      repeat (SETTLE) @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_block();
            csr_write(directed_rows[i].idx, directed_rows[i].data);
         end else begin
            send_access(directed_rows[i].core, directed_rows[i].addr, directed_rows[i].io,
                        directed_rows[i].kern, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random phases
      set_config(1'b1, 12'd16, 32'd10);
      run_random(60);

      // back to back, every beat dumps
      gaps_on = 0;
      set_config(1'b1, 12'd1, 32'd1);
      run_random(30);
      gaps_on = 1;

      set_config(1'b1, 12'd4095, 32'd25);
      run_random(50);

      // disabled: beats accepted and ignored
      set_config(1'b0, 12'd16, 32'd4);
      run_random(20);

      set_config(1'b1, BSZ_W'($urandom_range(1, 4095)), PERIOD_W'($urandom_range(2, 40)));
      run_random(60);

      set_config(1'b1, 12'd0, 32'd5);
      run_random(30);

      // receiver holds off while beats keep coming: queue fills, req_ready drops
      set_config(1'b1, 12'd16, 32'd3);
      gaps_on      = 0;
      hold_results = 1;
      run_random(70);
      gaps_on = 1;

      drain_block();
      if (errors == 0 && pending_dumps.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
